FILE: hw/rtl/lhnc_pkg.sv
// ============================================================================
// lhnc_pkg
// Shared types, character codes and helpers for the local host name classifier.
// ============================================================================
package lhnc_pkg;

    localparam int HEAD_DEPTH = 3;
    localparam int TAIL_DEPTH = 10;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_C   = 8'h63;
    localparam logic [7:0] CH_LO_D   = 8'h64;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_NINE_D = 8'h39;

    localparam logic [1:0] KIND_HOST = 2'd0;
    localparam logic [1:0] KIND_IPV4 = 2'd1;
    localparam logic [1:0] KIND_IPV6 = 2'd2;

    localparam logic [3:0] NAME_LEN_MAX = 4'd11;
    localparam logic [3:0] LEN_BARE     = 4'd9;
    localparam logic [3:0] LEN_LONG_MIN = 4'd10;
    localparam logic [3:0] LEN_SHORT_MIN = 4'd6;

    localparam logic [1:0] MAX_DIGITS  = 2'd3;
    localparam logic [1:0] LAST_OCTET  = 2'd3;
    localparam logic [9:0] OCTET_MAX   = 10'd255;

    // tail[9] is the oldest byte, tail[0] the newest
    localparam logic [79:0] WORD_DOT_LOCALHOST = ".localhost";
    localparam logic [71:0] WORD_LOCALHOST     = "localhost";
    localparam logic [47:0] WORD_DOT_LOCAL     = ".local";

    localparam logic [7:0] OCT_ZERO     = 8'd0;
    localparam logic [7:0] OCT_TEN      = 8'd10;
    localparam logic [7:0] OCT_LOOP     = 8'd127;
    localparam logic [7:0] OCT_172      = 8'd172;
    localparam logic [7:0] OCT_192      = 8'd192;
    localparam logic [7:0] OCT_168      = 8'd168;
    localparam logic [7:0] OCT_169      = 8'd169;
    localparam logic [7:0] OCT_254      = 8'd254;
    localparam logic [7:0] OCT_100      = 8'd100;
    localparam logic [3:0] B172_HI      = 4'h1;
    localparam logic [1:0] B100_HI      = 2'b01;

    typedef logic [HEAD_DEPTH-1:0][7:0] head_t;
    typedef logic [TAIL_DEPTH-1:0][7:0] tail_t;

    typedef struct packed {
        logic       quad_ok;
        logic [1:0] octet_index;
        logic [1:0] digit_count;
        logic [9:0] octet_value;
        logic [7:0] first_octet;
        logic [7:0] second_octet;
        logic       colon_seen;
        head_t      head;
        tail_t      tail;
        logic [3:0] name_length;
    } scan_view_t;

    function automatic logic [7:0] lhnc_fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/lhnc_scan.sv
// ============================================================================
// lhnc_scan
// Per-name scan state: dotted quad parser, colon flag, head bytes and the
// trailing byte window. Presents the state as it stands after the current byte.
// ============================================================================
module lhnc_scan import lhnc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic [7:0] ch,
    input  logic       last,
    output scan_view_t view
);

    scan_view_t st_reg;
    scan_view_t st_next;
    scan_view_t clear_val;
    logic [7:0] chf;
    logic       is_digit;

    always_comb begin
        clear_val = '0;
        clear_val.quad_ok = 1'b1;
    end

    always_comb begin
        chf      = lhnc_fold(ch);
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        view     = st_reg;
        if (st_reg.quad_ok) begin
            if (is_digit) begin
                if (st_reg.digit_count >= MAX_DIGITS) begin
                    view.quad_ok = 1'b0;
                end else begin
                    view.octet_value = 10'(st_reg.octet_value * 10'd10) + {6'b0, ch[3:0]};
                    view.digit_count = st_reg.digit_count + 2'd1;
                end
            end else if (ch == CH_DOT) begin
                if (st_reg.digit_count == 2'd0 || st_reg.octet_value > OCTET_MAX ||
                    st_reg.octet_index >= LAST_OCTET) begin
                    view.quad_ok = 1'b0;
                end else begin
                    if (st_reg.octet_index == 2'd0) begin
                        view.first_octet = st_reg.octet_value[7:0];
                    end
                    if (st_reg.octet_index == 2'd1) begin
                        view.second_octet = st_reg.octet_value[7:0];
                    end
                    view.octet_index = st_reg.octet_index + 2'd1;
                    view.digit_count = 2'd0;
                    view.octet_value = 10'd0;
                end
            end else begin
                view.quad_ok = 1'b0;
            end
        end
        if (ch == CH_COLON) begin
            view.colon_seen = 1'b1;
        end
        if (st_reg.name_length < 4'(HEAD_DEPTH)) begin
            view.head[st_reg.name_length[1:0]] = chf;
        end
        view.tail = {st_reg.tail[TAIL_DEPTH-2:0], chf};
        if (st_reg.name_length < NAME_LEN_MAX) begin
            view.name_length = st_reg.name_length + 4'd1;
        end
    end

    always_comb begin
        st_next = st_reg;
        if (take) begin
            st_next = last ? clear_val : view;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= clear_val;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

FILE: hw/rtl/lhnc_verdict.sv
// ============================================================================
// lhnc_verdict
// Verdict logic: IPv4 range test, IPv6 prefix test and local name suffix test.
// ============================================================================
module lhnc_verdict import lhnc_pkg::*; (
    input  scan_view_t view,
    output logic       is_local,
    output logic [1:0] kind
);

    logic       quad_done;
    logic       v4_local;
    logic       v6_local;
    logic       name_local;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] h0;
    logic [7:0] h1;
    logic [7:0] h2;

    always_comb begin
        a  = view.first_octet;
        b  = view.second_octet;
        h0 = view.head[0];
        h1 = view.head[1];
        h2 = view.head[2];
        quad_done = view.quad_ok && (view.octet_index == LAST_OCTET) &&
                    (view.digit_count != 2'd0) && (view.octet_value <= OCTET_MAX);
        v4_local = (a == OCT_ZERO) || (a == OCT_TEN) || (a == OCT_LOOP) ||
                   ((a == OCT_172) && (b[7:4] == B172_HI)) ||
                   ((a == OCT_192) && (b == OCT_168)) ||
                   ((a == OCT_169) && (b == OCT_254)) ||
                   ((a == OCT_100) && (b[7:6] == B100_HI));
        v6_local = (h0 == CH_COLON) ||
                   ((h0 == CH_LO_F) && ((h1 == CH_LO_C) || (h1 == CH_LO_D))) ||
                   ((h0 == CH_LO_F) && (h1 == CH_LO_E) &&
                    ((h2 == CH_EIGHT) || (h2 == CH_NINE_D) ||
                     (h2 == CH_LO_A) || (h2 == CH_LO_B)));
        name_local = ((view.name_length == LEN_BARE) &&
                      (view.tail[TAIL_DEPTH-2:0] == WORD_LOCALHOST)) ||
                     ((view.name_length > LEN_LONG_MIN) &&
                      (view.tail == WORD_DOT_LOCALHOST)) ||
                     ((view.name_length > LEN_SHORT_MIN) &&
                      (view.tail[5:0] == WORD_DOT_LOCAL));
        if (quad_done) begin
            kind     = KIND_IPV4;
            is_local = v4_local;
        end else if (view.colon_seen) begin
            kind     = KIND_IPV6;
            is_local = v6_local;
        end else begin
            kind     = KIND_HOST;
            is_local = name_local;
        end
    end

endmodule

FILE: hw/rtl/local_host_name_classifier_core.sv
// ============================================================================
// local_host_name_classifier_core
// Streams a host name one byte per beat and returns one local/kind verdict.
// ============================================================================
// One byte is taken every clock unless a final beat is held; non-final beats
// never stall. The final beat of a name loads its verdict into the result
// register as it leaves the input register; the only backpressure is a final
// beat waiting behind an untaken result. All per-name state is cleared when
// the verdict is formed, so names may follow each other with no gap.
module local_host_name_classifier_core import lhnc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_local,
    output logic [1:0] m_kind
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_ch_reg;
    logic       in_last_reg;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       is_local_reg;
    logic [1:0] kind_reg;
    logic       advance;
    logic       out_load;
    logic       v_local;
    logic [1:0] v_kind;
    scan_view_t view;

    assign advance  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign out_load = advance && in_last_reg;
    assign s_ready  = !in_valid_reg || advance;

    lhnc_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (advance),
        .ch      (in_ch_reg),
        .last    (in_last_reg),
        .view    (view)
    );

    lhnc_verdict u_verdict (
        .view     (view),
        .is_local (v_local),
        .kind     (v_kind)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg   <= s_ch;
            in_last_reg <= s_last;
        end
        if (out_load) begin
            is_local_reg <= v_local;
            kind_reg     <= v_kind;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_is_local = is_local_reg;
    assign m_kind     = kind_reg;

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(in_valid_reg && in_last_reg))
        else $error("result appeared without a final beat");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_kind == KIND_HOST || m_kind == KIND_IPV4 || m_kind == KIND_IPV6))
        else $error("result kind out of range");

    a_mid_name_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_last_reg) |-> s_ready)
        else $error("stall on a non-final beat");

endmodule
